/* rtl/waterfall_row_store_colormap_unit_defines.svh */
// Assertion macros for the waterfall row store checker.
// Depends on nothing; included by the checker file.
`ifndef WATERFALL_ROW_STORE_COLORMAP_UNIT_DEFINES_SVH
`define WATERFALL_ROW_STORE_COLORMAP_UNIT_DEFINES_SVH

// Concurrent assertion on an explicit clock and synchronous reset.
`define WRSC_CLK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on the block's own clock and reset names.
`define WRSC_ASSERT(label, prop, msg) \
   `WRSC_CLK_ASSERT(label, clock, reset, prop, msg)

`endif

/* rtl/wrsc_pkg.sv */
// Shared constants and the thermal palette function for the waterfall row store.
// Depends on nothing; imported by the top level, the checker and the testbench.
package wrsc_pkg;

   localparam int DEFAULT_ROW_WIDTH = 256;
   localparam int DEFAULT_ROW_COUNT = 128;

   localparam int LEVEL_W  = 8;
   localparam int AGE_W    = 7;
   localparam int COLUMN_W = 8;
   localparam int COLOR_W  = 16;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   // Palette segment boundaries.
   localparam logic [7:0] SEG_CYAN_START   = 8'd43;
   localparam logic [7:0] SEG_GREEN_START  = 8'd85;
   localparam logic [7:0] SEG_YELLOW_START = 8'd128;
   localparam logic [7:0] SEG_RED_START    = 8'd171;
   localparam logic [7:0] SEG_WHITE_START  = 8'd213;
   localparam logic [7:0] SEG_SLOPE        = 8'd6;
   localparam logic [7:0] CHANNEL_FULL     = 8'd255;

   // Level to thermal color, packed as RGB565 by truncating each channel.
   function automatic logic [COLOR_W-1:0] thermal_rgb565(input logic [LEVEL_W-1:0] lv);
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] t;
      logic [7:0] ramp;
      r = '0;
      g = '0;
      b = '0;
      priority if (lv < SEG_CYAN_START) begin
         t = lv;
      end else if (lv < SEG_GREEN_START) begin
         t = lv - SEG_CYAN_START;
      end else if (lv < SEG_YELLOW_START) begin
         t = lv - SEG_GREEN_START;
      end else if (lv < SEG_RED_START) begin
         t = lv - SEG_YELLOW_START;
      end else if (lv < SEG_WHITE_START) begin
         t = lv - SEG_RED_START;
      end else begin
         t = lv - SEG_WHITE_START;
      end
      // Every segment spans at most 43 steps, so the ramp stays within 8 bits.
      ramp = 8'(t * SEG_SLOPE);
      priority if (lv < SEG_CYAN_START) begin
         b = ramp;
      end else if (lv < SEG_GREEN_START) begin
         g = ramp;
         b = CHANNEL_FULL;
      end else if (lv < SEG_YELLOW_START) begin
         g = CHANNEL_FULL;
         b = CHANNEL_FULL - ramp;
      end else if (lv < SEG_RED_START) begin
         r = ramp;
         g = CHANNEL_FULL;
      end else if (lv < SEG_WHITE_START) begin
         r = CHANNEL_FULL;
         g = CHANNEL_FULL - ramp;
      end else begin
         r = CHANNEL_FULL;
         g = ramp;
         b = ramp;
      end
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

endpackage

/* rtl/wrsc_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing; used for the level store and the row length table.
module wrsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // Read data holds until the next read so a stalled consumer keeps it.
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/waterfall_row_store_colormap_unit.sv */
// Waterfall row store with thermal colormap: ring of level rows plus RGB565 lookup.
// Depends on wrsc_pkg and wrsc_ram.
//
// The block takes one transfer per cycle while ready, writes and reads mixed freely.
// A write stores one level in the newest row; a read's level goes to the stage-one
// registers, then its color to the result register, and a held result stalls the
// input only once the single stage behind it is also occupied. The figure is set by
// the level memory and the row length memory, each of which does one read and one
// write per cycle. No clearing pass is needed after reset: a count of opened rows
// marks which row lengths are meaningful, and reads never go past a row's length.
module waterfall_row_store_colormap_unit
   import wrsc_pkg::*;
#(
   parameter int ROW_WIDTH = DEFAULT_ROW_WIDTH,
   parameter int ROW_COUNT = DEFAULT_ROW_COUNT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   input  logic [LEVEL_W-1:0]  req_level,
   input  logic                req_row_end,
   input  logic [AGE_W-1:0]    req_row_age,
   input  logic [COLUMN_W-1:0] req_column,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [COLOR_W-1:0]  rsp_pixel_color
);

   localparam int RIW = $clog2(ROW_COUNT);
   localparam int CIW = $clog2(ROW_WIDTH);
   localparam int LW  = $clog2(ROW_WIDTH + 1);
   localparam int OW  = $clog2(ROW_COUNT + 1);
   localparam int AW  = $clog2(ROW_COUNT * ROW_WIDTH);
   localparam int SW  = ((RIW > AGE_W) ? RIW : AGE_W) + 1;
   localparam int CW  = (LW > COLUMN_W) ? LW : COLUMN_W;
   localparam int GW  = (OW > AGE_W) ? OW : AGE_W;

   // Control state.
   logic [RIW-1:0] newest_ff, newest_in;
   logic           row_open_ff, row_open_in;
   logic [LW-1:0]  cur_len_ff, cur_len_in;
   logic [OW-1:0]  opened_ff, opened_in;
   logic           s1_valid_ff, s1_valid_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // Read pipeline payload.
   logic           s1_age_zero_ff, s1_age_zero_in;
   logic           s1_age_ok_ff, s1_age_ok_in;
   logic [LW-1:0]  s1_cur_len_ff, s1_cur_len_in;
   logic [CW-1:0]  s1_col_ff, s1_col_in;
   logic [COLOR_W-1:0] rsp_color_ff, rsp_color_in;

   logic req_fire, wr_fire, rd_fire, out_free;

   // Write side.
   logic           open_row;
   logic [RIW-1:0] next_row, wr_slot;
   logic [LW-1:0]  wr_len, new_len;
   logic           room;
   logic [AW-1:0]  lvl_wr_addr;

   // Read side.
   logic [SW-1:0]  age_ext, newest_ext, slot_wide;
   logic [RIW-1:0] rd_slot;
   logic [CW-1:0]  col_ext;
   logic           age_zero, age_ok;
   logic [AW-1:0]  lvl_rd_addr;

   logic [LEVEL_W-1:0] lvl_rd_data;
   logic [LW-1:0]      len_rd_data;
   logic [LW-1:0]      s1_len;
   logic               s1_hit;
   logic [LEVEL_W-1:0] s1_level;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;
   assign wr_fire   = req_fire && (req_kind == KIND_WRITE);
   assign rd_fire   = req_fire && (req_kind == KIND_READ);

   always_comb begin
      open_row    = !row_open_ff;
      next_row    = (newest_ff == RIW'(ROW_COUNT - 1)) ? '0 : newest_ff + 1'b1;
      wr_slot     = open_row ? next_row : newest_ff;
      wr_len      = open_row ? '0 : cur_len_ff;
      room        = wr_len < LW'(ROW_WIDTH);
      new_len     = room ? wr_len + 1'b1 : wr_len;
      lvl_wr_addr = AW'(wr_slot) * AW'(ROW_WIDTH) + AW'(wr_len[CIW-1:0]);
   end

   always_comb begin
      age_ext    = SW'(req_row_age);
      newest_ext = SW'(newest_ff);
      if (newest_ext >= age_ext) begin
         slot_wide = newest_ext - age_ext;
      end else begin
         slot_wide = newest_ext + SW'(ROW_COUNT) - age_ext;
      end
      rd_slot  = slot_wide[RIW-1:0];
      col_ext  = CW'(req_column);
      age_zero = (req_row_age == '0);
      // Older rows count only once they have been opened since reset.
      age_ok   = age_zero || (GW'(req_row_age) < GW'(opened_ff));
      lvl_rd_addr = AW'(rd_slot) * AW'(ROW_WIDTH) + AW'(col_ext[CIW-1:0]);
   end

   wrsc_ram #(
      .WIDTH(LEVEL_W),
      .DEPTH(ROW_COUNT * ROW_WIDTH)
   ) u_level_ram (
      .clock  (clock),
      .wr_en  (wr_fire && room),
      .wr_addr(lvl_wr_addr),
      .wr_data(req_level),
      .rd_en  (rd_fire),
      .rd_addr(lvl_rd_addr),
      .rd_data(lvl_rd_data)
   );

   wrsc_ram #(
      .WIDTH(LW),
      .DEPTH(ROW_COUNT)
   ) u_length_ram (
      .clock  (clock),
      .wr_en  (wr_fire),
      .wr_addr(wr_slot),
      .wr_data(new_len),
      .rd_en  (rd_fire),
      .rd_addr(rd_slot),
      .rd_data(len_rd_data)
   );

   // The newest row's length lives in cur_len_ff; the table serves older rows.
   always_comb begin
      s1_len   = s1_age_zero_ff ? s1_cur_len_ff : len_rd_data;
      s1_hit   = s1_age_ok_ff && (s1_col_ff < CW'(s1_len));
      s1_level = s1_hit ? lvl_rd_data : '0;
   end

   always_comb begin
      newest_in   = newest_ff;
      row_open_in = row_open_ff;
      cur_len_in  = cur_len_ff;
      opened_in   = opened_ff;
      if (wr_fire) begin
         newest_in   = wr_slot;
         row_open_in = !req_row_end;
         cur_len_in  = new_len;
         if (open_row && (opened_ff != OW'(ROW_COUNT))) begin
            opened_in = opened_ff + 1'b1;
         end
      end

      if (req_fire) begin
         s1_valid_in = rd_fire;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      s1_age_zero_in = rd_fire ? age_zero : s1_age_zero_ff;
      s1_age_ok_in   = rd_fire ? age_ok : s1_age_ok_ff;
      s1_cur_len_in  = rd_fire ? cur_len_ff : s1_cur_len_ff;
      s1_col_in      = rd_fire ? col_ext : s1_col_ff;

      rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;
      rsp_color_in = (out_free && s1_valid_ff) ? thermal_rgb565(s1_level) : rsp_color_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         newest_ff    <= '0;
         row_open_ff  <= 1'b0;
         cur_len_ff   <= '0;
         opened_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         newest_ff    <= newest_in;
         row_open_ff  <= row_open_in;
         cur_len_ff   <= cur_len_in;
         opened_ff    <= opened_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_age_zero_ff <= s1_age_zero_in;
      s1_age_ok_ff   <= s1_age_ok_in;
      s1_cur_len_ff  <= s1_cur_len_in;
      s1_col_ff      <= s1_col_in;
      rsp_color_ff   <= rsp_color_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_color = rsp_color_ff;

endmodule

/* rtl/wrsc_checker.sv */
// Port-level checker for the waterfall row store, bound to the top level.
// Depends on wrsc_pkg and the assertion macro header.
`include "waterfall_row_store_colormap_unit_defines.svh"

module wrsc_checker
   import wrsc_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                req_kind,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [COLOR_W-1:0]  rsp_pixel_color
);

   // A stalled result keeps its color.
   `WRSC_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_color), "result changed while stalled")

   // With the result port empty nothing can block the input.
   `WRSC_ASSERT(a_ready_when_empty, !rsp_valid |-> req_ready, "input blocked with no pending result")

   // A read transfer is always followed by a result showing once it has passed the stage-one and result registers.
   `WRSC_ASSERT(a_read_result, req_valid && req_ready && (req_kind == KIND_READ) |-> ##2 rsp_valid, "read transfer produced no result")

   // A result only appears as the consequence of a read transfer.
   `WRSC_ASSERT(a_no_invented, $rose(rsp_valid) |-> $past(req_valid && req_ready && (req_kind == KIND_READ), 2), "result without a read transfer")

endmodule

bind waterfall_row_store_colormap_unit wrsc_checker u_wrsc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_kind       (req_kind),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_pixel_color(rsp_pixel_color)
);

/* tb/tb_top.sv */
// Self-checking testbench for waterfall_row_store_colormap_unit: level rows in, RGB565 pixels out.
// Depends on wrsc_pkg and the unit itself. It keeps its own copy of the row ring and
// palette, and compares every returned pixel against it.
`timescale 1ns / 1ps

module tb_top
   import wrsc_pkg::*;
();

   localparam int ROWS = DEFAULT_ROW_COUNT;
   localparam int COLS = DEFAULT_ROW_WIDTH;
   localparam int ITEMS_PER_PHASE = 325;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic                kind;
      logic [LEVEL_W-1:0]  level;
      logic                row_end;
      logic [AGE_W-1:0]    row_age;
      logic [COLUMN_W-1:0] column;
   } waterfall_item_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_kind = KIND_WRITE;
   logic [LEVEL_W-1:0]  req_level = '0;
   logic                req_row_end = 1'b0;
   logic [AGE_W-1:0]    req_row_age = '0;
   logic [COLUMN_W-1:0] req_column = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [COLOR_W-1:0]  rsp_pixel_color;

   waterfall_row_store_colormap_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_level      (req_level),
      .req_row_end    (req_row_end),
      .req_row_age    (req_row_age),
      .req_column     (req_column),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_color(rsp_pixel_color)
   );

   // Items waiting to be presented, and pixel colors owed by accepted reads.
   waterfall_item_type item_q[$];
   logic [COLOR_W-1:0] pixel_colors_due[$];
   waterfall_item_type cur_item;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int fail_count = 0;
   int items_built = 0;

   // Our own copy of the row ring.
   logic [LEVEL_W-1:0] level_rows [ROWS][COLS];
   int                 row_fill [ROWS];
   int                 head_row = 0;
   bit                 row_active = 1'b0;

   // Stimulus-side bookkeeping, used only to aim reads at rows that hold data.
   int gen_rows_opened = 0;
   bit gen_row_open = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Six-segment thermal palette: black, blue, cyan, green, yellow, red, white,
   // each channel truncated into RGB565.
   function automatic logic [COLOR_W-1:0] thermal_pixel(input logic [LEVEL_W-1:0] lv);
      int v;
      int red;
      int grn;
      int blu;
      v = int'(lv);
      red = 0;
      grn = 0;
      blu = 0;
      if (v < 43) begin
         blu = 6 * v;
      end else if (v < 85) begin
         grn = 6 * (v - 43);
         blu = 255;
      end else if (v < 128) begin
         grn = 255;
         blu = 255 - 6 * (v - 85);
      end else if (v < 171) begin
         red = 6 * (v - 128);
         grn = 255;
      end else if (v < 213) begin
         red = 255;
         grn = 255 - 6 * (v - 171);
      end else begin
         red = 255;
         grn = 6 * (v - 213);
         blu = 6 * (v - 213);
      end
      return {red[7:3], grn[7:2], blu[7:3]};
   endfunction

   // Applies one accepted transfer to the ring; a read queues the color it owes.
   function automatic void commit_item(input waterfall_item_type it);
      int slot;
      int col;
      logic [LEVEL_W-1:0] lv;
      if (it.kind == KIND_WRITE) begin
         if (!row_active) begin
            head_row = (head_row + 1) % ROWS;
            row_fill[head_row] = 0;
            row_active = 1'b1;
         end
         if (row_fill[head_row] < COLS) begin
            level_rows[head_row][row_fill[head_row]] = it.level;
            row_fill[head_row]++;
         end
         if (it.row_end) begin
            row_active = 1'b0;
         end
      end else begin
         lv = '0;
         col = int'(it.column);
         if (int'(it.row_age) < ROWS && col < COLS) begin
            slot = (head_row + ROWS - int'(it.row_age)) % ROWS;
            if (col < row_fill[slot]) begin
               lv = level_rows[slot][col];
            end
         end
         pixel_colors_due.push_back(thermal_pixel(lv));
      end
   endfunction

   task automatic push_write(input int lv, input bit last);
      waterfall_item_type it;
      it.kind = KIND_WRITE;
      it.level = lv[LEVEL_W-1:0];
      it.row_end = last;
      it.row_age = AGE_W'($urandom);
      it.column = COLUMN_W'($urandom);
      item_q.push_back(it);
      items_built++;
      if (!gen_row_open) begin
         gen_rows_opened++;
         gen_row_open = 1'b1;
      end
      if (last) begin
         gen_row_open = 1'b0;
      end
   endtask

   task automatic push_read(input int age, input int col);
      waterfall_item_type it;
      it.kind = KIND_READ;
      it.level = LEVEL_W'($urandom);
      it.row_end = 1'($urandom);
      it.row_age = age[AGE_W-1:0];
      it.column = col[COLUMN_W-1:0];
      item_q.push_back(it);
      items_built++;
   endtask

   // One row of random levels, now and then read back while still open.
   task automatic emit_row(input int len);
      for (int i = 0; i < len; i++) begin
         if (i > 0 && $urandom_range(99) < 15) begin
            push_read(0, $urandom_range(i + 1));
         end
         push_write($urandom_range(255), i == len - 1);
      end
   endtask

   task automatic emit_reads(input int n);
      int age_top;
      int pick;
      age_top = (gen_rows_opened + 1 < ROWS - 1) ? gen_rows_opened + 1 : ROWS - 1;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            push_read($urandom_range(age_top), $urandom_range(15));
         end else if (pick < 75) begin
            push_read($urandom_range(age_top), $urandom_range(63));
         end else begin
            push_read($urandom_range(ROWS - 1), $urandom_range(COLS - 1));
         end
      end
   endtask

   task automatic emit_directed();
      int seg_levels[8] = '{0, 42, 43, 127, 128, 212, 213, 255};
      // Nothing has been written yet, so every row is black.
      push_read(0, 0);
      push_read(ROWS - 1, COLS - 1);
      for (int i = 0; i < 8; i++) begin
         push_write(seg_levels[i], i == 7);
         if (i == 3) begin
            push_read(0, 1);
         end
      end
      for (int c = 0; c < 8; c++) begin
         push_read(0, c);
      end
      // Past the end of a short row, and the row that was never opened.
      push_read(0, 8);
      push_read(1, 0);
      push_write(200, 1'b1);
      push_read(0, 0);
      push_read(1, 3);
   endtask

   task automatic wait_drained();
      while (item_q.size() != 0 || req_valid || pixel_colors_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Driver: presents queued items and holds each one until it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            commit_item(cur_item);
         end
         if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            cur_item = item_q.pop_front();
            req_valid <= 1'b1;
            req_kind <= cur_item.kind;
            req_level <= cur_item.level;
            req_row_end <= cur_item.row_end;
            req_row_age <= cur_item.row_age;
            req_column <= cur_item.column;
         end else begin
            req_valid <= 1'b0;
            req_kind <= 1'($urandom);
            req_level <= LEVEL_W'($urandom);
            req_row_end <= 1'($urandom);
            req_row_age <= AGE_W'($urandom);
            req_column <= COLUMN_W'($urandom);
         end
      end
   end

   // Monitor: checks each returned pixel against the oldest owed color.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pixel_colors_due.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("%0t: unexpected pixel transfer, color %h", $realtime,
                           rsp_pixel_color);
               end
            end else begin
               if (rsp_pixel_color !== pixel_colors_due[0]) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("%0t: pixel_color mismatch, expected %h, got %h", $realtime,
                              pixel_colors_due[0], rsp_pixel_color);
                  end
               end
               void'(pixel_colors_due.pop_front());
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      int idle_plan[4][2];
      int pick;
      idle_plan = '{'{0, 0}, '{49, 0}, '{0, 49}, '{11, 11}};
      for (int r = 0; r < ROWS; r++) begin
         row_fill[r] = 0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_plan[ph][0];
         recv_stall_pct = idle_plan[ph][1];
         if (ph == 0) begin
            emit_directed();
         end
         if (ph == 2) begin
            // A row long enough to run past the row width.
            emit_row($urandom_range(COLS + 1, COLS + 34));
            emit_reads(4);
         end
         while (items_built < (ph + 1) * ITEMS_PER_PHASE) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
               pick = $urandom_range(99);
               if (pick < 89) begin
                  emit_row($urandom_range(1, 4));
               end else if (pick < 99) begin
                  emit_row($urandom_range(5, 24));
               end else begin
                  emit_row($urandom_range(COLS - 6, COLS + 10));
               end
            end else begin
               emit_reads($urandom_range(1, 3));
            end
         end
         // Let the block go quiet before the next idling pattern starts.
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0 && pixel_colors_due.size() == 0) begin
         $display("** waterfall_row_store_colormap_unit: PASSED **");
      end else begin
         $display("** waterfall_row_store_colormap_unit: FAILED **");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("** waterfall_row_store_colormap_unit: FAILED **");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/wrsc_pkg.sv
rtl/wrsc_ram.sv
rtl/waterfall_row_store_colormap_unit.sv
rtl/wrsc_checker.sv
tb/tb_top.sv
